// File: rtl/core/osa_pkg.sv
// Shared types, constants and a helper function for the attention head core.
package osa_pkg;

    localparam int SCORE_W  = 40;
    localparam int WEIGHT_W = 17;
    localparam int SUM_W    = 32;
    localparam int ACC_W    = 48;
    localparam int DACC_W   = 58;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] EXP_FLOOR = -40'sd1048576;
    localparam logic [30:0] TERM_ONE = 31'h4000_0000;
    localparam logic [3:0] EXP_TERMS = 4'd10;

    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_VALUE = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_SEQ_LENGTH  = 2'd0,
        CFG_HEAD_SIZE   = 2'd1,
        CFG_SCORE_SCALE = 2'd2,
        CFG_CAUSAL_ON   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCORE,
        ST_DRAIN,
        ST_WRD,
        ST_WDIFF,
        ST_WEXP,
        ST_ACC,
        ST_ADRAIN,
        ST_ORD,
        ST_OSTART,
        ST_OWAIT,
        ST_OPUT
    } top_state_t;

    typedef enum logic [2:0] {
        EXP_IDLE,
        EXP_MUL,
        EXP_RCP,
        EXP_FIX,
        EXP_POW,
        EXP_DONE
    } exp_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } exp_res_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] q;
    } div_res_t;

    function automatic logic [31:0] recip(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // exp(-1) in Q2.30 from the ten-term series
    localparam logic [31:0] EXP_E1 = 32'd395007567;

endpackage

// File: rtl/core/osa_exp.sv
// Iterative fixed-point exponential unit producing one softmax weight.
module osa_exp import osa_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [SCORE_W-1:0] diff,
    output exp_res_t                  res
);

    exp_state_t          state_reg, state_next;
    logic [30:0]         term_reg, term_next;
    logic [31:0]         sum_reg, sum_next;
    logic [15:0]         r_reg, r_next;
    logic [4:0]          kcnt_reg, kcnt_next;
    logic [3:0]          idx_reg, idx_next;
    logic [46:0]         prod_reg, prod_next;
    logic [30:0]         x_reg, x_next;
    logic [63:0]         xr_reg, xr_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;

    logic [SCORE_W-1:0]  neg_diff;
    logic [31:0]         q0, qi, rem, qfix;

    assign neg_diff = (diff > 0) ? '0 : SCORE_W'(-diff);
    assign q0   = xr_reg[63:32];
    assign qi   = q0 * {28'd0, idx_reg};
    assign rem  = {1'b0, x_reg} - qi;
    assign qfix = (rem >= {28'd0, idx_reg}) ? q0 + 32'd1 : q0;

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        r_next     = r_reg;
        kcnt_next  = kcnt_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        xr_next    = xr_reg;
        w_next     = w_reg;
        res.done   = 1'b0;
        res.weight = w_reg;
        case (state_reg)
            EXP_IDLE: begin
                if (start) begin
                    if (diff < EXP_FLOOR) begin
                        w_next     = '0;
                        state_next = EXP_DONE;
                    end else begin
                        kcnt_next  = neg_diff[20:16];
                        r_next     = neg_diff[15:0];
                        term_next  = TERM_ONE;
                        sum_next   = {1'b0, TERM_ONE};
                        idx_next   = 4'd1;
                        state_next = EXP_MUL;
                    end
                end
            end
            EXP_MUL: begin
                prod_next  = {16'd0, term_reg} * {31'd0, r_reg};
                state_next = EXP_RCP;
            end
            EXP_RCP: begin
                x_next     = prod_reg[46:16];
                xr_next    = {33'd0, prod_reg[46:16]} * {32'd0, recip(idx_reg)};
                state_next = EXP_FIX;
            end
            EXP_FIX: begin
                term_next = qfix[30:0];
                if (idx_reg[0])
                    sum_next = (qfix > sum_reg) ? '0 : sum_reg - qfix;
                else
                    sum_next = sum_reg + qfix;
                if (idx_reg == EXP_TERMS) begin
                    state_next = EXP_POW;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = EXP_MUL;
                end
            end
            EXP_POW: begin
                if (kcnt_reg == 5'd0) begin
                    w_next     = WEIGHT_W'(({1'b0, sum_reg} + 33'd8192) >> 14);
                    state_next = EXP_DONE;
                end else begin
                    sum_next  = 32'(({32'd0, sum_reg} * {32'd0, EXP_E1}) >> 30);
                    kcnt_next = kcnt_reg - 5'd1;
                end
            end
            EXP_DONE: begin
                res.done   = 1'b1;
                state_next = EXP_IDLE;
            end
            default: state_next = EXP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= EXP_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
        sum_reg  <= sum_next;
        r_reg    <= r_next;
        kcnt_reg <= kcnt_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        xr_reg   <= xr_next;
        w_reg    <= w_next;
    end

endmodule

// File: rtl/core/osa_div.sv
// Restoring divider giving the rounded, saturated output element.
module osa_div import osa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] acc,
    input  logic [SUM_W-1:0]        den,
    output div_res_t                res
);

    div_state_t         state_reg, state_next;
    logic [49:0]        rem_reg, rem_next;
    logic [49:0]        dsh_reg, dsh_next;
    logic [14:0]        qacc_reg, qacc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] q_reg, q_next;

    logic [ACC_W-1:0]   mag;
    logic [49:0]        num;
    logic [32:0]        den2;
    logic               bit_take;
    logic [14:0]        qacc_step;

    assign mag       = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign num       = {1'b0, mag, 1'b0} + {18'd0, den};
    assign den2      = {den, 1'b0};
    assign bit_take  = rem_reg >= dsh_reg;
    assign qacc_step = {qacc_reg[13:0], bit_take};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        qacc_next  = qacc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        res.done   = 1'b0;
        res.q      = q_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    neg_next = acc[ACC_W-1];
                    if (den == '0) begin
                        q_next     = '0;
                        state_next = DIV_DONE;
                    end else if (num >= {2'b0, den2, 15'd0}) begin
                        q_next     = acc[ACC_W-1] ? 16'sh8000 : 16'sh7FFF;
                        state_next = DIV_DONE;
                    end else begin
                        rem_next   = num;
                        dsh_next   = {3'b0, den2, 14'd0};
                        qacc_next  = '0;
                        cnt_next   = 4'd14;
                        state_next = DIV_RUN;
                    end
                end
            end
            DIV_RUN: begin
                if (bit_take)
                    rem_next = rem_reg - dsh_reg;
                dsh_next  = dsh_reg >> 1;
                qacc_next = qacc_step;
                if (cnt_reg == 4'd0) begin
                    q_next     = neg_reg ? -$signed({1'b0, qacc_step}) : $signed({1'b0, qacc_step});
                    state_next = DIV_DONE;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            DIV_DONE: begin
                res.done   = 1'b1;
                state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        qacc_reg <= qacc_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
    end

endmodule

// File: rtl/core/online_softmax_attention_head_top.sv
// Attention head top level: key, value, query, score and accumulator stores and the scan sequencer.
// Input beats are accepted only while the sequencer is idle. A scan after the last query beat
// computes all scores, then for each key a weight and its accumulation (a key whose score
// lies below the floor skips the series), then each output element through the divider,
// which is shorter when saturated; input is held off until the last output beat is loaded.
// Reset (aresetn, synchronous, active low) resets control and configuration; stores keep contents.
module online_softmax_attention_head_top import osa_pkg::*; #(
    parameter int MAX_SEQ  = 64,
    parameter int MAX_HEAD = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [5:0]         s_position,
    input  logic [5:0]         s_element_index,
    input  logic signed [15:0] s_element_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_out_index,
    output logic signed [15:0] m_out_value,
    output logic               m_out_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int SEQ_AW   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int HEAD_AW  = (MAX_HEAD > 1) ? $clog2(MAX_HEAD) : 1;
    localparam int KV_AW    = SEQ_AW + HEAD_AW;
    localparam int KV_DEPTH = 1 << KV_AW;

    logic [6:0]  seq_length_reg;
    logic [6:0]  head_size_reg;
    logic [15:0] score_scale_reg;
    logic        causal_on_reg;

    top_state_t         state_reg, state_next;
    logic [SEQ_AW-1:0]  kc_reg, kc_next;
    logic [HEAD_AW-1:0] jc_reg, jc_next;
    logic               m_valid_reg, m_valid_next;

    logic [SEQ_AW-1:0]  ns_cfg, nk_cfg, nk_reg;
    logic [HEAD_AW-1:0] hs_cfg, hs_reg;
    logic               in_fire, kv_in_range, q_in_ok, scan_go;
    logic               out_load, exp_start, div_start;

    logic signed [15:0]      kmem [KV_DEPTH];
    logic signed [15:0]      vmem [KV_DEPTH];
    logic signed [15:0]      qmem [1 << HEAD_AW];
    logic signed [SCORE_W-1:0] smem [1 << SEQ_AW];
    logic signed [ACC_W-1:0] amem [1 << HEAD_AW];

    logic signed [15:0]        kmem_rd, vmem_rd, qmem_rd;
    logic signed [SCORE_W-1:0] score_rd;
    logic signed [ACC_W-1:0]   acc_rd;

    logic               p0_vld_reg, p1_vld_reg, p2_vld_reg;
    logic               p0_first_reg, p1_first_reg, p2_first_reg;
    logic               p0_last_reg, p1_last_reg, p2_last_reg;
    logic [SEQ_AW-1:0]  p0_k_reg, p1_k_reg, p2_k_reg;
    logic signed [31:0] p1_prod_reg;
    logic signed [48:0] p2_sp_reg;
    logic signed [DACC_W-1:0]  dacc_reg, dot_sum;
    logic signed [SCORE_W-1:0] score_new, max_reg, wdiff;

    logic                    a0_vld_reg, a1_vld_reg, a0_zero_reg;
    logic [HEAD_AW-1:0]      a0_j_reg, a1_j_reg;
    logic signed [33:0]      a1_prod_reg;
    logic signed [ACC_W-1:0] a1_acc_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic signed [15:0]  q_reg;
    logic [5:0]          oidx_reg;
    logic signed [15:0]  oval_reg;
    logic                olast_reg;

    exp_res_t exp_res;
    div_res_t div_res;

    always_comb begin
        if (seq_length_reg == 7'd0)
            ns_cfg = '0;
        else if (int'(seq_length_reg) > MAX_SEQ)
            ns_cfg = SEQ_AW'(MAX_SEQ - 1);
        else
            ns_cfg = SEQ_AW'(seq_length_reg - 7'd1);
        if (head_size_reg == 7'd0)
            hs_cfg = '0;
        else if (int'(head_size_reg) > MAX_HEAD)
            hs_cfg = HEAD_AW'(MAX_HEAD - 1);
        else
            hs_cfg = HEAD_AW'(head_size_reg - 7'd1);
        if (causal_on_reg && int'(s_position) < int'(ns_cfg))
            nk_cfg = SEQ_AW'(s_position);
        else
            nk_cfg = ns_cfg;
    end

    assign s_ready     = state_reg == ST_IDLE;
    assign cfg_ready   = 1'b1;
    assign in_fire     = s_valid && s_ready;
    assign kv_in_range = int'(s_position) < MAX_SEQ && int'(s_element_index) < MAX_HEAD;
    assign q_in_ok     = int'(s_element_index) <= int'(hs_cfg);
    assign scan_go     = in_fire && s_opcode == OP_QUERY && q_in_ok
                         && HEAD_AW'(s_element_index) == hs_cfg;

    assign dot_sum   = (p2_first_reg ? DACC_W'(0) : dacc_reg) + DACC_W'(p2_sp_reg);
    assign score_new = SCORE_W'(dot_sum >>> 24);
    assign wdiff     = score_rd - max_reg;

    always_comb begin
        state_next   = state_reg;
        kc_next      = kc_reg;
        jc_next      = jc_reg;
        m_valid_next = m_valid_reg;
        out_load     = 1'b0;
        exp_start    = 1'b0;
        div_start    = 1'b0;
        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (scan_go) begin
                    kc_next    = '0;
                    jc_next    = '0;
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (jc_reg == hs_reg) begin
                    jc_next = '0;
                    if (kc_reg == nk_reg) begin
                        kc_next    = '0;
                        state_next = ST_DRAIN;
                    end else begin
                        kc_next = kc_reg + SEQ_AW'(1);
                    end
                end else begin
                    jc_next = jc_reg + HEAD_AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!p0_vld_reg && !p1_vld_reg && !p2_vld_reg)
                    state_next = ST_WRD;
            end
            ST_WRD: state_next = ST_WDIFF;
            ST_WDIFF: begin
                exp_start  = 1'b1;
                state_next = ST_WEXP;
            end
            ST_WEXP: begin
                if (exp_res.done) begin
                    jc_next    = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (jc_reg == hs_reg) begin
                    jc_next    = '0;
                    state_next = ST_ADRAIN;
                end else begin
                    jc_next = jc_reg + HEAD_AW'(1);
                end
            end
            ST_ADRAIN: begin
                if (!a0_vld_reg && !a1_vld_reg) begin
                    if (kc_reg == nk_reg) begin
                        state_next = ST_ORD;
                    end else begin
                        kc_next    = kc_reg + SEQ_AW'(1);
                        state_next = ST_WRD;
                    end
                end
            end
            ST_ORD: state_next = ST_OSTART;
            ST_OSTART: begin
                div_start  = 1'b1;
                state_next = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (div_res.done)
                    state_next = ST_OPUT;
            end
            ST_OPUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    if (jc_reg == hs_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        jc_next    = jc_reg + HEAD_AW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            kc_reg          <= '0;
            jc_reg          <= '0;
            m_valid_reg     <= 1'b0;
            p0_vld_reg      <= 1'b0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
            a0_vld_reg      <= 1'b0;
            a1_vld_reg      <= 1'b0;
            seq_length_reg  <= 7'd64;
            head_size_reg   <= 7'd64;
            score_scale_reg <= 16'd8192;
            causal_on_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kc_reg      <= kc_next;
            jc_reg      <= jc_next;
            m_valid_reg <= m_valid_next;
            p0_vld_reg  <= state_reg == ST_SCORE;
            p1_vld_reg  <= p0_vld_reg;
            p2_vld_reg  <= p1_vld_reg;
            a0_vld_reg  <= state_reg == ST_ACC;
            a1_vld_reg  <= a0_vld_reg;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEQ_LENGTH:  seq_length_reg  <= cfg_data[6:0];
                    CFG_HEAD_SIZE:   head_size_reg   <= cfg_data[6:0];
                    CFG_SCORE_SCALE: score_scale_reg <= cfg_data;
                    CFG_CAUSAL_ON:   causal_on_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_opcode == OP_KEY && kv_in_range)
            kmem[{SEQ_AW'(s_position), HEAD_AW'(s_element_index)}] <= s_element_value;
        if (in_fire && s_opcode == OP_VALUE && kv_in_range)
            vmem[{SEQ_AW'(s_position), HEAD_AW'(s_element_index)}] <= s_element_value;
        if (in_fire && s_opcode == OP_QUERY && q_in_ok)
            qmem[HEAD_AW'(s_element_index)] <= s_element_value;
        if (p2_vld_reg && p2_last_reg)
            smem[p2_k_reg] <= score_new;
        if (a1_vld_reg)
            amem[a1_j_reg] <= a1_acc_reg + ACC_W'(a1_prod_reg);
        kmem_rd  <= kmem[{kc_reg, jc_reg}];
        vmem_rd  <= vmem[{kc_reg, jc_reg}];
        qmem_rd  <= qmem[jc_reg];
        score_rd <= smem[kc_reg];
        acc_rd   <= amem[jc_reg];
    end

    always_ff @(posedge aclk) begin
        p0_first_reg <= jc_reg == '0;
        p0_last_reg  <= jc_reg == hs_reg;
        p0_k_reg     <= kc_reg;
        p1_first_reg <= p0_first_reg;
        p1_last_reg  <= p0_last_reg;
        p1_k_reg     <= p0_k_reg;
        p1_prod_reg  <= qmem_rd * kmem_rd;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_k_reg     <= p1_k_reg;
        p2_sp_reg    <= p1_prod_reg * $signed({1'b0, score_scale_reg});
        a0_j_reg     <= jc_reg;
        a0_zero_reg  <= kc_reg == '0;
        a1_j_reg     <= a0_j_reg;
        a1_prod_reg  <= $signed({1'b0, w_reg}) * vmem_rd;
        a1_acc_reg   <= a0_zero_reg ? ACC_W'(0) : acc_rd;
        if (scan_go) begin
            hs_reg  <= hs_cfg;
            nk_reg  <= nk_cfg;
            max_reg <= SCORE_MIN;
            sum_reg <= '0;
        end
        if (p2_vld_reg) begin
            dacc_reg <= dot_sum;
            if (p2_last_reg && score_new > max_reg)
                max_reg <= score_new;
        end
        if (exp_res.done) begin
            w_reg   <= exp_res.weight;
            sum_reg <= sum_reg + SUM_W'(exp_res.weight);
        end
        if (div_res.done)
            q_reg <= div_res.q;
        if (out_load) begin
            oidx_reg  <= 6'(jc_reg);
            oval_reg  <= q_reg;
            olast_reg <= jc_reg == hs_reg;
        end
    end

    osa_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .diff    (wdiff),
        .res     (exp_res)
    );

    osa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .acc     (acc_rd),
        .den     (sum_reg),
        .res     (div_res)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_index = oidx_reg;
    assign m_out_value = oval_reg;
    assign m_out_last  = olast_reg;

`ifndef SYNTH
    a_score_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WDIFF |-> score_rd <= max_reg)
        else $error("score above running maximum");

    a_sum_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OSTART |-> sum_reg != '0)
        else $error("weight sum empty at output");

    a_acc_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (a1_vld_reg && state_reg == ST_ACC) |-> a1_j_reg != jc_reg)
        else $error("accumulator read and write collide");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the online softmax attention head: predicts each output beat and compares.
module tb;
    import osa_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         SLOTS     = 64 * 64;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  pos;
        logic [5:0]  idx;
        logic [15:0] val;
    } attn_beat_t;

    typedef struct {
        logic [5:0]  idx;
        logic [15:0] val;
        logic        last;
    } attn_out_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = '0;
    logic [5:0]         s_position = '0;
    logic [5:0]         s_element_index = '0;
    logic signed [15:0] s_element_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_out_index;
    logic signed [15:0] m_out_value;
    logic               m_out_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    online_softmax_attention_head_top u_top (.*);

    attn_beat_t  beat_pend_q[$];
    attn_out_t   attn_expect_q[$];
    logic        s_took = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          scans = 0;

    // predictor copy of stores and registers
    logic [15:0] key_mem[SLOTS];
    logic [15:0] val_mem[SLOTS];
    logic [15:0] qry_mem[64];
    logic [6:0]  m_seq = 7'd64;
    logic [6:0]  m_head = 7'd64;
    logic [15:0] m_scale = 16'd8192;
    logic        m_causal = 1'b0;

    // stimulus-side record of written entries
    bit          key_set[SLOTS];
    bit          val_set[SLOTS];

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int eff_len(logic [6:0] v);
        if (v == 0) return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic longint unsigned exp_frac_q30(longint unsigned r);
        longint unsigned term;
        longint unsigned sum;
        term = 64'd1 << 30;
        sum  = term;
        for (int i = 1; i <= 10; i++) begin
            term = ((term * r) >> 16) / longint'(i);
            if (i % 2 == 1)
                sum = (term > sum) ? 64'd0 : sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint exp_weight(longint d);
        longint unsigned a;
        longint unsigned e;
        longint unsigned e1;
        longint unsigned k;
        if (d > 0) d = 0;
        if (d < -(longint'(16) << 16)) return 0;
        a  = longint'(-d);
        k  = a >> 16;
        e  = exp_frac_q30(a & 64'hFFFF);
        e1 = exp_frac_q30(64'd65536);
        for (longint unsigned i = 0; i < k; i++)
            e = (e * e1) >> 30;
        return longint'((e + 64'd8192) >> 14);
    endfunction

    task automatic predict_attention(input logic [5:0] qpos);
        int        ns;
        int        hs;
        longint    score[64];
        bit        used[64];
        longint    peak;
        longint    wsum;
        longint    acc[64];
        longint    dot;
        longint    w;
        longint    mag;
        longint    qm;
        attn_out_t o;
        ns   = eff_len(m_seq);
        hs   = eff_len(m_head);
        peak = -(longint'(1) << 39);
        wsum = 0;
        for (int j = 0; j < 64; j++) acc[j] = 0;
        for (int k = 0; k < ns; k++) begin
            used[k]  = !(m_causal && k > qpos);
            score[k] = 0;
            if (used[k]) begin
                dot = 0;
                for (int j = 0; j < hs; j++)
                    dot += longint'($signed(qry_mem[j])) * longint'($signed(key_mem[k*64+j]));
                score[k] = (dot * longint'(m_scale)) >>> 24;
                if (score[k] > peak) peak = score[k];
            end
        end
        for (int k = 0; k < ns; k++) begin
            if (used[k]) begin
                w = exp_weight(score[k] - peak);
                wsum += w;
                for (int j = 0; j < hs; j++)
                    acc[j] += w * longint'($signed(val_mem[k*64+j]));
            end
        end
        for (int j = 0; j < hs; j++) begin
            qm = 0;
            if (wsum != 0) begin
                mag = (acc[j] < 0) ? -acc[j] : acc[j];
                qm  = (2 * mag + wsum) / (2 * wsum);
                if (qm > 32768) qm = 32768;
                if (acc[j] < 0) qm = -qm;
                if (qm > 32767) qm = 32767;
            end
            o.idx  = 6'(j);
            o.val  = 16'(qm);
            o.last = (j == hs - 1);
            attn_expect_q.push_back(o);
        end
        scans++;
    endtask

    // record accepted input beats and track the block's state
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEQ_LENGTH:  m_seq <= cfg_data[6:0];
                    CFG_HEAD_SIZE:   m_head <= cfg_data[6:0];
                    CFG_SCORE_SCALE: m_scale <= cfg_data;
                    CFG_CAUSAL_ON:   m_causal <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                beats_in++;
                case (s_opcode)
                    OP_KEY:   key_mem[s_position*64 + s_element_index] = s_element_value;
                    OP_VALUE: val_mem[s_position*64 + s_element_index] = s_element_value;
                    OP_QUERY: begin
                        if (s_element_index < eff_len(m_head)) begin
                            qry_mem[s_element_index] = s_element_value;
                            if (s_element_index == eff_len(m_head) - 1)
                                predict_attention(s_position);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // check output beats
    always @(posedge aclk) begin
        attn_out_t e;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (attn_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: index %0d value %0d last %0b",
                             m_out_index, m_out_value, m_out_last);
            end else begin
                e = attn_expect_q.pop_front();
                if (m_out_index !== e.idx || m_out_value !== e.val || m_out_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                                 e.idx, $signed(e.val), e.last,
                                 m_out_index, m_out_value, m_out_last);
                end
            end
        end
    end

    // driver and receiver stalls
    always @(negedge aclk) begin
        attn_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!s_valid || s_took) begin
                if (beat_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    b = beat_pend_q.pop_front();
                    s_opcode        <= b.op;
                    s_position      <= b.pos;
                    s_element_index <= b.idx;
                    s_element_value <= b.val;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic push_beat(input logic [1:0] op, input int pos, input int idx,
                             input logic [15:0] val);
        attn_beat_t b;
        b.op  = op;
        b.pos = 6'(pos);
        b.idx = 6'(idx);
        b.val = val;
        if (op == OP_KEY) key_set[pos*64 + idx] = 1'b1;
        if (op == OP_VALUE) val_set[pos*64 + idx] = 1'b1;
        beat_pend_q.push_back(b);
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(8191)) - 16'd4096;
            1:       return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (beat_pend_q.size() != 0 || s_valid || attn_expect_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int seq, input int head, input int scale, input int causal);
        wait_idle();
        write_reg(CFG_SEQ_LENGTH, 16'(seq));
        write_reg(CFG_HEAD_SIZE, 16'(head));
        write_reg(CFG_SCORE_SCALE, 16'(scale));
        write_reg(CFG_CAUSAL_ON, 16'(causal));
    endtask

    // write every key and value the next scans will read
    task automatic fill_region(input int seq, input int head);
        int ns;
        int hs;
        ns = eff_len(7'(seq));
        hs = eff_len(7'(head));
        for (int k = 0; k < ns; k++)
            for (int j = 0; j < hs; j++) begin
                if (!key_set[k*64+j]) push_beat(OP_KEY, k, j, rand_val());
                if (!val_set[k*64+j]) push_beat(OP_VALUE, k, j, rand_val());
            end
    endtask

    task automatic query_seq(input int hs, input int qpos, input logic [15:0] fixed, input bit use_fixed);
        int order[$];
        int t;
        int r;
        for (int j = 0; j < hs - 1; j++) order.push_back(j);
        for (int j = order.size() - 1; j > 0; j--) begin
            r = $urandom_range(j);
            t = order[j]; order[j] = order[r]; order[r] = t;
        end
        foreach (order[i])
            push_beat(OP_QUERY, $urandom_range(63), order[i], use_fixed ? fixed : rand_val());
        push_beat(OP_QUERY, qpos, hs - 1, use_fixed ? fixed : rand_val());
    endtask

    task automatic random_phase(input int nitems);
        int seq;
        int head;
        int hs;
        int ns;
        int start;
        seq   = $urandom_range(1, 8);
        head  = $urandom_range(1, 4);
        configure(seq, head, $urandom_range(3) == 0 ? $urandom : $urandom_range(16384),
                  $urandom_range(1));
        hs = eff_len(7'(head));
        ns = eff_len(7'(seq));
        fill_region(seq, head);
        start = beats_in + beat_pend_q.size();
        while (beats_in + beat_pend_q.size() - start < nitems) begin
            case ($urandom_range(9))
                0:       push_beat(OP_UNUSED, $urandom_range(63), $urandom_range(63), 16'($urandom));
                1:       push_beat(OP_QUERY, $urandom_range(63), $urandom_range(hs, 63), 16'($urandom));
                2:       push_beat(OP_KEY, $urandom_range(ns - 1), $urandom_range(hs - 1), rand_val());
                3:       push_beat(OP_VALUE, $urandom_range(63), $urandom_range(63), 16'($urandom));
                4:       push_beat(OP_QUERY, $urandom_range(63), $urandom_range(hs - 1), rand_val());
                default: query_seq(hs, $urandom_range(63), 16'd0, 1'b0);
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero lengths, full scale, extreme data
        configure(0, 0, 65535, 0);
        push_beat(OP_KEY, 0, 0, 16'h7FFF);
        push_beat(OP_VALUE, 0, 0, 16'h8000);
        push_beat(OP_UNUSED, 63, 63, 16'hFFFF);
        push_beat(OP_QUERY, 5, 1, 16'h1234);
        push_beat(OP_QUERY, 0, 0, 16'h8000);
        push_beat(OP_VALUE, 0, 0, 16'h7FFF);
        push_beat(OP_QUERY, 63, 0, 16'h7FFF);
        configure(2, 1, 65535, 1);
        push_beat(OP_KEY, 1, 0, 16'h8000);
        push_beat(OP_VALUE, 1, 0, 16'h0000);
        push_beat(OP_QUERY, 0, 0, 16'h7FFF);
        push_beat(OP_QUERY, 1, 0, 16'h8000);

        // largest sizes, causal masking at both ends, oversized lengths, zero scale
        configure(64, 1, 8192, 1);
        fill_region(64, 1);
        query_seq(1, 0, 16'd0, 1'b0);
        query_seq(1, 63, 16'h0800, 1'b1);
        configure(127, 1, 0, 0);
        query_seq(1, 17, 16'd0, 1'b0);
        configure(1, 127, 65535, 0);
        fill_region(1, 64);
        query_seq(64, 17, 16'd0, 1'b0);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 87 : 29) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 87 : 29) : 0;
            for (int r = 0; r < 3; r++) random_phase(7);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        wait_idle();
        repeat (200) @(posedge aclk);
        if (attn_expect_q.size() != 0) mismatches++;
        $display("accepted %0d input beats, %0d scans, %0d output beats", beats_in, scans, beats_out);
        $display("sizes 1..64, causal on and off, scale 0..65535, four idling mixes");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
